@@ rtl/tvb_pkg.sv @@
// ----------------------------------------------------------------------------
// tvb_pkg
// Shared types and constants of the transformed vertex bounds block: register
// indexes and reset values, queue sizing, finisher states.
// ----------------------------------------------------------------------------
package tvb_pkg;

	// Fixed field widths
	localparam int AXES            = 3;
	localparam int COEF_FIELD_BITS = 18;
	localparam int GAIN_BITS       = 16;
	localparam int GAIN_FRAC_BITS  = 14;
	localparam int CFG_DATA_BITS   = 3 * COEF_FIELD_BITS;
	localparam int CFG_INDEX_BITS  = 3;

	// Box queue between the accumulator and the finisher
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_BITS = 1;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	// Register indexes
	localparam cfg_index_t REG_MATRIX_COL0    = 3'd0;
	localparam cfg_index_t REG_MATRIX_COL1    = 3'd1;
	localparam cfg_index_t REG_MATRIX_COL2    = 3'd2;
	localparam cfg_index_t REG_POSE_X         = 3'd3;
	localparam cfg_index_t REG_POSE_Y         = 3'd4;
	localparam cfg_index_t REG_POSE_Z         = 3'd5;
	localparam cfg_index_t REG_CONTACT_MARGIN = 3'd6;
	localparam cfg_index_t REG_INFLATE_GAIN   = 3'd7;

	// Reset values: identity matrix, unit gain
	localparam logic [CFG_DATA_BITS-1:0] MATRIX_COL0_RESET = 54'h0_0000_0000_4000;
	localparam logic [CFG_DATA_BITS-1:0] MATRIX_COL1_RESET = 54'h0_0001_0000_0000;
	localparam logic [CFG_DATA_BITS-1:0] MATRIX_COL2_RESET = 54'h4_0000_0000_0000;
	localparam logic [GAIN_BITS-1:0]     INFLATE_GAIN_RESET = 16'd16384;

	// Queue status seen by producer and consumer
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	// Finisher sequence
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_POSE,
		BK_SPREAD,
		BK_SCALE,
		BK_FINISH
	} back_state_t;

endpackage

@@ rtl/tvb_front.sv @@
// ----------------------------------------------------------------------------
// tvb_front
// Vertex transform pipeline and running min/max accumulator. Pushes one box
// request into the queue on each vertex marked last.
// ----------------------------------------------------------------------------
module tvb_front #(
	parameter int COORD_BITS     = 24,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic signed [COORD_BITS-1:0] vert_z,
	input  logic last_vertex,
	input  logic [tvb_pkg::AXES-1:0][tvb_pkg::CFG_DATA_BITS-1:0] matrix,
	input  tvb_pkg::q_stat_t q_stat,
	output logic push,
	output logic [2*tvb_pkg::AXES*COORD_BITS-1:0] push_data
);

	localparam int CF_W   = tvb_pkg::COEF_FIELD_BITS;
	localparam int PROD_W = CF_W + COORD_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	function automatic logic signed [COORD_BITS-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
		if (x > SUM_W'(CMAX)) begin
			return CMAX;
		end else if (x < SUM_W'(CMIN)) begin
			return CMIN;
		end
		return x[COORD_BITS-1:0];
	endfunction

	logic signed [COORD_BITS-1:0] vert [tvb_pkg::AXES];
	logic signed [CF_W-1:0]       coef [tvb_pkg::AXES][tvb_pkg::AXES];
	logic signed [PROD_W-1:0]     prod [tvb_pkg::AXES][tvb_pkg::AXES];
	logic signed [PROD_W-1:0]     prod_s1 [tvb_pkg::AXES][tvb_pkg::AXES];
	logic signed [SUM_W-1:0]      row_sum [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] t_s2 [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] run_min_q [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] run_max_q [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] new_min [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] new_max [tvb_pkg::AXES];
	logic valid_s1, valid_s2, last_s1, last_s2, seen_q, advance;

	assign vert[0] = vert_x;
	assign vert[1] = vert_y;
	assign vert[2] = vert_z;

	// Hold the whole pipeline while a finished box has no room in the queue
	assign advance  = !(valid_s2 && last_s2 && q_stat.full);
	assign in_stall = !advance;
	assign push     = valid_s2 && last_s2 && !q_stat.full;

	// Unpack coefficients (row r of column c) and form the nine products
	always_comb begin
		for (int r = 0; r < tvb_pkg::AXES; r++) begin
			for (int c = 0; c < tvb_pkg::AXES; c++) begin
				coef[r][c] = matrix[c][r*CF_W +: CF_W];
				prod[r][c] = coef[r][c] * vert[c];
			end
		end
	end

	// Row sums, round half up, saturate
	always_comb begin
		for (int r = 0; r < tvb_pkg::AXES; r++) begin
			row_sum[r] = SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
				+ SUM_W'(prod_s1[r][2]) + ROUND_HALF;
		end
	end

	// Fold the transformed vertex into the running box
	always_comb begin
		for (int r = 0; r < tvb_pkg::AXES; r++) begin
			new_min[r] = (!seen_q || t_s2[r] < run_min_q[r]) ? t_s2[r] : run_min_q[r];
			new_max[r] = (!seen_q || t_s2[r] > run_max_q[r]) ? t_s2[r] : run_max_q[r];
		end
		push_data = {new_max[2], new_max[1], new_max[0], new_min[2], new_min[1], new_min[0]};
	end

	// Advance valid bits and the first-vertex flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			seen_q   <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				seen_q <= !last_s2;
			end
		end
	end

	// Pipeline payload and running extremes
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= prod;
			last_s1 <= last_vertex;
			last_s2 <= last_s1;
			for (int r = 0; r < tvb_pkg::AXES; r++) begin
				t_s2[r] <= sat_sum(row_sum[r] >>> COEF_FRAC_BITS);
			end
			if (valid_s2 && !last_s2) begin
				run_min_q <= new_min;
				run_max_q <= new_max;
			end
		end
	end

endmodule

@@ rtl/tvb_queue.sv @@
// ----------------------------------------------------------------------------
// tvb_queue
// Short register queue of finished raw boxes between accumulator and
// finisher.
// ----------------------------------------------------------------------------
module tvb_queue #(
	parameter int WIDTH = 144
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	input  logic pop,
	output logic [WIDTH-1:0] pop_data,
	output tvb_pkg::q_stat_t stat
);

	localparam int CNT_W = tvb_pkg::QUEUE_PTR_BITS + 1;

	logic [WIDTH-1:0] mem_q [tvb_pkg::QUEUE_DEPTH];
	logic [tvb_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full      = (count_q == CNT_W'(tvb_pkg::QUEUE_DEPTH));
	assign stat.not_empty = (count_q != '0);
	assign pop_data       = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/tvb_back.sv @@
// ----------------------------------------------------------------------------
// tvb_back
// Box finisher: margin, pose translation and half-extent inflation over a
// short sequence, with an output register toward the result channel.
// ----------------------------------------------------------------------------
module tvb_back #(
	parameter int COORD_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  tvb_pkg::q_stat_t q_stat,
	output logic pop,
	input  logic [2*tvb_pkg::AXES*COORD_BITS-1:0] pop_data,
	input  logic [COORD_BITS-2:0] margin,
	input  logic [tvb_pkg::AXES-1:0][COORD_BITS-1:0] pose,
	input  logic [tvb_pkg::GAIN_BITS-1:0] gain,
	output logic out_valid,
	input  logic out_stall,
	output logic [tvb_pkg::AXES-1:0][COORD_BITS-1:0] box_min,
	output logic [tvb_pkg::AXES-1:0][COORD_BITS-1:0] box_max
);

	localparam int SAT_W  = COORD_BITS + 4;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = DIFF_W + tvb_pkg::GAIN_BITS + 1;
	localparam int MIX_W  = PROD_W + 1;
	localparam int SHIFT  = tvb_pkg::GAIN_FRAC_BITS + 1;
	localparam logic signed [MIX_W-1:0] ROUND_HALF = MIX_W'(1) << tvb_pkg::GAIN_FRAC_BITS;
	localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SAT_W-1:0] x);
		if (x > SAT_W'(CMAX)) begin
			return CMAX;
		end else if (x < SAT_W'(CMIN)) begin
			return CMIN;
		end
		return x[COORD_BITS-1:0];
	endfunction

	tvb_pkg::back_state_t state_q, state_d;

	logic signed [COORD_BITS-1:0] lo_q [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] hi_q [tvb_pkg::AXES];
	logic signed [DIFF_W-1:0]     s_q  [tvb_pkg::AXES];
	logic signed [DIFF_W-1:0]     d_q  [tvb_pkg::AXES];
	logic signed [PROD_W-1:0]     e_q  [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] raw_min [tvb_pkg::AXES];
	logic signed [COORD_BITS-1:0] raw_max [tvb_pkg::AXES];
	logic signed [MIX_W-1:0]      mix_lo [tvb_pkg::AXES];
	logic signed [MIX_W-1:0]      mix_hi [tvb_pkg::AXES];
	logic signed [SAT_W-1:0]      margin_ext;
	logic signed [tvb_pkg::GAIN_BITS:0] gain_ext;
	logic out_valid_q, fire;

	assign out_valid  = out_valid_q;
	assign margin_ext = SAT_W'($signed({1'b0, margin}));
	assign gain_ext   = $signed({1'b0, gain});
	assign fire       = !out_valid_q || !out_stall;

	// Unpack the raw box and form the centre/extent mixes
	always_comb begin
		for (int r = 0; r < tvb_pkg::AXES; r++) begin
			raw_min[r] = $signed(pop_data[r*COORD_BITS +: COORD_BITS]);
			raw_max[r] = $signed(pop_data[(tvb_pkg::AXES+r)*COORD_BITS +: COORD_BITS]);
			mix_lo[r]  = (MIX_W'(s_q[r]) <<< tvb_pkg::GAIN_FRAC_BITS) - MIX_W'(e_q[r])
				+ ROUND_HALF;
			mix_hi[r]  = (MIX_W'(s_q[r]) <<< tvb_pkg::GAIN_FRAC_BITS) + MIX_W'(e_q[r])
				+ ROUND_HALF;
		end
	end

	// Sequence: take a box, translate, spread, scale, finish
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			tvb_pkg::BK_IDLE: begin
				if (q_stat.not_empty) begin
					pop     = 1'b1;
					state_d = tvb_pkg::BK_POSE;
				end
			end
			tvb_pkg::BK_POSE:   state_d = tvb_pkg::BK_SPREAD;
			tvb_pkg::BK_SPREAD: state_d = tvb_pkg::BK_SCALE;
			tvb_pkg::BK_SCALE:  state_d = tvb_pkg::BK_FINISH;
			tvb_pkg::BK_FINISH: begin
				if (fire) begin
					state_d = tvb_pkg::BK_IDLE;
				end
			end
			default: state_d = tvb_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tvb_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tvb_pkg::BK_FINISH && fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of each step
	always_ff @(posedge clk) begin
		for (int r = 0; r < tvb_pkg::AXES; r++) begin
			case (state_q)
				tvb_pkg::BK_IDLE: begin
					lo_q[r] <= sat(SAT_W'(raw_min[r]) - margin_ext);
					hi_q[r] <= sat(SAT_W'(raw_max[r]) + margin_ext);
				end
				tvb_pkg::BK_POSE: begin
					lo_q[r] <= sat(SAT_W'(lo_q[r]) + SAT_W'($signed(pose[r])));
					hi_q[r] <= sat(SAT_W'(hi_q[r]) + SAT_W'($signed(pose[r])));
				end
				tvb_pkg::BK_SPREAD: begin
					s_q[r] <= DIFF_W'(hi_q[r]) + DIFF_W'(lo_q[r]);
					d_q[r] <= DIFF_W'(hi_q[r]) - DIFF_W'(lo_q[r]);
				end
				tvb_pkg::BK_SCALE: begin
					e_q[r] <= d_q[r] * gain_ext;
				end
				tvb_pkg::BK_FINISH: begin
					if (fire) begin
						box_min[r] <= sat(SAT_W'(mix_lo[r] >>> SHIFT));
						box_max[r] <= sat(SAT_W'(mix_hi[r] >>> SHIFT));
					end
				end
				default: begin
					lo_q[r] <= lo_q[r];
				end
			endcase
		end
	end

endmodule

@@ rtl/transformed_vertex_bounds.sv @@
// Axis-aligned bounding box of a transformed vertex stream. Vertices enter on
// the input channel at one per cycle unless in_stall holds them; each is
// multiplied by the configured 3x3 matrix (two pipeline stages) and folded
// into the running min/max. The vertex marked last closes the mesh and moves
// its raw box into a two-entry queue. A finisher takes each box in turn through
// margin, pose, centre/extent, gain multiply and rounding to the output
// register. Meshes of five or more vertices stream at one vertex per cycle
// while the output is not stalled; shorter meshes are bounded by the finisher
// once the queue fills. Configuration is written by the user only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// transformed_vertex_bounds
// Top level: configuration registers, transform front end, box queue and
// box finisher.
// ----------------------------------------------------------------------------
module transformed_vertex_bounds #(
	parameter int COORD_BITS     = 24,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic cfg_we,
	input  tvb_pkg::cfg_index_t cfg_index,
	input  logic [tvb_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// vertex requests
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic signed [COORD_BITS-1:0] vert_z,
	input  logic last_vertex,
	// box requests
	output logic out_valid,
	input  logic out_stall,
	output logic signed [COORD_BITS-1:0] box_min_x,
	output logic signed [COORD_BITS-1:0] box_min_y,
	output logic signed [COORD_BITS-1:0] box_min_z,
	output logic signed [COORD_BITS-1:0] box_max_x,
	output logic signed [COORD_BITS-1:0] box_max_y,
	output logic signed [COORD_BITS-1:0] box_max_z
);

	localparam int BOX_W = 2 * tvb_pkg::AXES * COORD_BITS;

	logic [tvb_pkg::AXES-1:0][tvb_pkg::CFG_DATA_BITS-1:0] matrix_q;
	logic [tvb_pkg::AXES-1:0][COORD_BITS-1:0] pose_q;
	logic [COORD_BITS-2:0] margin_q;
	logic [tvb_pkg::GAIN_BITS-1:0] gain_q;

	logic push, pop;
	logic [BOX_W-1:0] push_data, pop_data;
	tvb_pkg::q_stat_t q_stat;
	logic [tvb_pkg::AXES-1:0][COORD_BITS-1:0] box_min, box_max;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q[0] <= tvb_pkg::MATRIX_COL0_RESET;
			matrix_q[1] <= tvb_pkg::MATRIX_COL1_RESET;
			matrix_q[2] <= tvb_pkg::MATRIX_COL2_RESET;
			pose_q      <= '0;
			margin_q    <= '0;
			gain_q      <= tvb_pkg::INFLATE_GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tvb_pkg::REG_MATRIX_COL0:    matrix_q[0] <= cfg_data;
				tvb_pkg::REG_MATRIX_COL1:    matrix_q[1] <= cfg_data;
				tvb_pkg::REG_MATRIX_COL2:    matrix_q[2] <= cfg_data;
				tvb_pkg::REG_POSE_X:         pose_q[0]   <= cfg_data[COORD_BITS-1:0];
				tvb_pkg::REG_POSE_Y:         pose_q[1]   <= cfg_data[COORD_BITS-1:0];
				tvb_pkg::REG_POSE_Z:         pose_q[2]   <= cfg_data[COORD_BITS-1:0];
				tvb_pkg::REG_CONTACT_MARGIN: margin_q    <= cfg_data[COORD_BITS-2:0];
				tvb_pkg::REG_INFLATE_GAIN:   gain_q      <= cfg_data[tvb_pkg::GAIN_BITS-1:0];
				default: begin
					gain_q <= gain_q;
				end
			endcase
		end
	end

	tvb_front #(
		.COORD_BITS     (COORD_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.vert_z      (vert_z),
		.last_vertex (last_vertex),
		.matrix      (matrix_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	tvb_queue #(
		.WIDTH (BOX_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	tvb_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop       (pop),
		.pop_data  (pop_data),
		.margin    (margin_q),
		.pose      (pose_q),
		.gain      (gain_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.box_min   (box_min),
		.box_max   (box_max)
	);

	assign box_min_x = box_min[0];
	assign box_min_y = box_min[1];
	assign box_min_z = box_min[2];
	assign box_max_x = box_max[0];
	assign box_max_y = box_max[1];
	assign box_max_z = box_max[2];

endmodule

@@ dv/transformed_vertex_bounds_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transformed_vertex_bounds_test
// Sends meshes of vertices through the bounds block under several matrix, pose,
// margin and gain settings, with random gaps and stalls on both channels, and
// checks every box against a bit-exact fixed point predictor of the block or a directed expected box.
// ----------------------------------------------------------------------------
module transformed_vertex_bounds_test;
	import tvb_pkg::*;

	localparam int CW         = 24;
	localparam int COEF_FRAC  = 14;
	localparam int QUIET_MAX  = 3000;
	localparam int SETTLE_CYC = 20;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 140;

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [2:0][CW-1:0] lo;
		logic [2:0][CW-1:0] hi;
	} box_t;

	typedef enum logic {ROW_VERT, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		cfg_index_t                idx;
		logic [CFG_DATA_BITS-1:0]  data;
		logic signed [CW-1:0]      x;
		logic signed [CW-1:0]      y;
		logic signed [CW-1:0]      z;
		logic                      last;
		logic                      typed;
		box_t                      box;
	} step_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = REG_MATRIX_COL0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] vert_x = '0;
	logic signed [CW-1:0] vert_y = '0;
	logic signed [CW-1:0] vert_z = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [CW-1:0] box_max_x, box_max_y, box_max_z;

	// Predictor copy of the registers and the running box
	logic [CFG_DATA_BITS-1:0] mat_col [3];
	logic signed [CW-1:0] pose [3];
	logic [CW-2:0] margin;
	logic [GAIN_BITS-1:0] gain;
	longint run_lo [3];
	longint run_hi [3];
	bit mesh_open;

	box_t expected_boxes [$];
	step_row_t script [$];
	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	string axis_letters = "xyz";

	transformed_vertex_bounds u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.vert_x     (vert_x),
		.vert_y     (vert_y),
		.vert_z     (vert_z),
		.last_vertex(last_vertex),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.box_min_x  (box_min_x),
		.box_min_y  (box_min_y),
		.box_min_z  (box_min_z),
		.box_max_x  (box_max_x),
		.box_max_y  (box_max_y),
		.box_max_z  (box_max_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp(input longint v);
		if (v > longint'(COORD_MAX))
			return longint'(COORD_MAX);
		if (v < longint'(COORD_MIN))
			return longint'(COORD_MIN);
		return v;
	endfunction

	// round half up, then floor shift
	function automatic longint shift_round(input longint v, input int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	// Fold one vertex into the running box; on the last vertex build the box
	function automatic bit bound_vertex(input logic signed [CW-1:0] vx, vy, vz,
			input logic last, output box_t box);
		longint v [3];
		longint acc, t, lo, hi, s, d, c2, e2;
		v[0] = vx;
		v[1] = vy;
		v[2] = vz;
		box = '0;
		for (int a = 0; a < 3; a++) begin
			acc = 0;
			for (int c = 0; c < 3; c++)
				acc += longint'($signed(mat_col[c][a*COEF_FIELD_BITS +: COEF_FIELD_BITS]))
					* v[c];
			t = clamp(shift_round(acc, COEF_FRAC));
			if (!mesh_open) begin
				run_lo[a] = t;
				run_hi[a] = t;
			end else begin
				if (t < run_lo[a])
					run_lo[a] = t;
				if (t > run_hi[a])
					run_hi[a] = t;
			end
		end
		mesh_open = 1'b1;
		if (!last)
			return 1'b0;
		// margin, pose, then scale the half extents about the centre
		for (int a = 0; a < 3; a++) begin
			lo = clamp(run_lo[a] - longint'(margin));
			hi = clamp(run_hi[a] + longint'(margin));
			lo = clamp(lo + longint'(pose[a]));
			hi = clamp(hi + longint'(pose[a]));
			s  = hi + lo;
			d  = hi - lo;
			c2 = s * (longint'(1) << GAIN_FRAC_BITS);
			e2 = d * longint'(gain);
			lo = clamp(shift_round(c2 - e2, GAIN_FRAC_BITS + 1));
			hi = clamp(shift_round(c2 + e2, GAIN_FRAC_BITS + 1));
			box.lo[a] = lo[CW-1:0];
			box.hi[a] = hi[CW-1:0];
			run_lo[a] = 0;
			run_hi[a] = 0;
		end
		mesh_open = 1'b0;
		return 1'b1;
	endfunction

	function automatic box_t box_of(input logic signed [CW-1:0] lx, ly, lz, hx, hy, hz);
		box_t b;
		b.lo[0] = lx;
		b.lo[1] = ly;
		b.lo[2] = lz;
		b.hi[0] = hx;
		b.hi[1] = hy;
		b.hi[2] = hz;
		return b;
	endfunction

	function automatic step_row_t vtx(input logic signed [CW-1:0] x, y, z, input logic last);
		step_row_t r;
		r = '0;
		r.kind = ROW_VERT;
		r.x = x;
		r.y = y;
		r.z = z;
		r.last = last;
		return r;
	endfunction

	function automatic step_row_t vtx_box(input logic signed [CW-1:0] x, y, z, input box_t b);
		step_row_t r;
		r = vtx(x, y, z, 1'b1);
		r.typed = 1'b1;
		r.box = b;
		return r;
	endfunction

	function automatic step_row_t reg_row(input cfg_index_t idx,
			input logic [CFG_DATA_BITS-1:0] data);
		step_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] random_coord();
		logic signed [CW-1:0] c;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: c = COORD_MAX;
					1: c = COORD_MIN;
					2: c = '0;
					default: c = '1;
				endcase
			end
			1, 2, 3, 4: c = CW'($urandom);
			default: c = CW'($urandom_range(0, 8191) - 4096);
		endcase
		return c;
	endfunction

	// Write one register and mirror it in the predictor
	task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MATRIX_COL0:    mat_col[0] = data;
			REG_MATRIX_COL1:    mat_col[1] = data;
			REG_MATRIX_COL2:    mat_col[2] = data;
			REG_POSE_X:         pose[0] = data[CW-1:0];
			REG_POSE_Y:         pose[1] = data[CW-1:0];
			REG_POSE_Z:         pose[2] = data[CW-1:0];
			REG_CONTACT_MARGIN: margin = data[CW-2:0];
			REG_INFLATE_GAIN:   gain = data[GAIN_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Present one vertex request, wait for it to be taken, record any box due
	task automatic push_vertex(input logic signed [CW-1:0] vx, vy, vz, input logic last,
			input bit typed, input box_t want);
		box_t pred;
		while (!calm && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vert_x <= vx;
		vert_y <= vy;
		vert_z <= vz;
		last_vertex <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (bound_vertex(vx, vy, vz, last, pred))
			expected_boxes.push_back(typed ? want : pred);
	endtask

	// Drop valid and let every pending box drain
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_boxes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Check box requests, drive the output stall, watch for a hang
	always @(posedge clk) begin
		box_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = box_of(box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z);
			if (expected_boxes.size() == 0) begin
				$error("box request with no mesh pending");
				errors++;
			end else begin
				want = expected_boxes.pop_front();
				for (int a = 0; a < 3; a++) begin
					if (got.lo[a] !== want.lo[a]) begin
						$error("box_min_%c: expected %0d, got %0d", axis_letters[a],
							$signed(want.lo[a]), $signed(got.lo[a]));
						errors++;
					end
					if (got.hi[a] !== want.hi[a]) begin
						$error("box_max_%c: expected %0d, got %0d", axis_letters[a],
							$signed(want.hi[a]), $signed(got.hi[a]));
						errors++;
					end
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("transformed_vertex_bounds regression: fail");
			$finish;
		end
		out_stall <= !calm && ($urandom_range(0, 99) < 34);
	end

	initial begin
		logic [CFG_DATA_BITS-1:0] mat [3];
		logic [CFG_DATA_BITS-1:0] px, py, pz, mg, gn;
		int coefv;
		int sent;
		int mesh_len;
		int r;

		mat_col[0] = MATRIX_COL0_RESET;
		mat_col[1] = MATRIX_COL1_RESET;
		mat_col[2] = MATRIX_COL2_RESET;
		for (int a = 0; a < 3; a++) begin
			pose[a] = '0;
			run_lo[a] = 0;
			run_hi[a] = 0;
		end
		margin = '0;
		gain = INFLATE_GAIN_RESET;
		mesh_open = 1'b0;

		// Identity after reset: the box is the raw min/max of the vertices
		script.push_back(vtx_box(COORD_MAX, COORD_MAX, COORD_MAX,
			box_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX)));
		script.push_back(vtx_box(COORD_MIN, COORD_MIN, COORD_MIN,
			box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN)));
		// first vertex replaces the cleared state, zeros play no part
		script.push_back(vtx(100, 200, 300, 1'b0));
		script.push_back(vtx(50, 60, 70, 1'b0));
		script.push_back(vtx_box(80, -10, 400, box_of(50, -10, 70, 100, 200, 400)));
		script.push_back(vtx(-1, 0, 1, 1'b0));
		script.push_back(vtx_box(1, 0, -1, box_of(-1, 0, -1, 1, 0, 1)));
		script.push_back(vtx(COORD_MAX, COORD_MIN, 0, 1'b0));
		script.push_back(vtx_box(COORD_MIN, COORD_MAX, -1,
			box_of(COORD_MIN, COORD_MIN, -1, COORD_MAX, COORD_MAX, 0)));
		// negative coefficient: x mirrors, the most negative x saturates
		script.push_back(reg_row(REG_MATRIX_COL0, {18'h0, 18'h0, 18'h3C000}));
		script.push_back(vtx_box(COORD_MIN, 5, 5, box_of(COORD_MAX, 5, 5, COORD_MAX, 5, 5)));
		script.push_back(reg_row(REG_MATRIX_COL1, {18'h0, 18'h04000, 18'h1FFFF}));
		script.push_back(reg_row(REG_MATRIX_COL2, {18'h20000, 18'h0, 18'h0}));
		// upper data bits set where the register is narrower
		script.push_back(reg_row(REG_POSE_X, {30'h2AAAAAAA, 24'hFFFF00}));
		script.push_back(reg_row(REG_POSE_Y, {30'h15555555, 24'h7FFFFF}));
		script.push_back(reg_row(REG_POSE_Z, {30'h0, 24'h800000}));
		script.push_back(reg_row(REG_CONTACT_MARGIN, {31'h40000001, 23'd384}));
		script.push_back(reg_row(REG_INFLATE_GAIN, {38'h2AAAAAAAAA, 16'h8000}));
		script.push_back(vtx(1000, -2000, 3000, 1'b0));
		script.push_back(vtx(-4000, 2500, -70000, 1'b0));
		script.push_back(vtx(300, 12, 9, 1'b1));
		script.push_back(reg_row(REG_INFLATE_GAIN, {38'h3FFFFFFFFF, 16'h0000}));
		script.push_back(vtx(2560, -512, 77, 1'b0));
		script.push_back(vtx(-2560, 512, -77, 1'b1));
		script.push_back(reg_row(REG_INFLATE_GAIN, {38'h0, 16'hFFFF}));
		script.push_back(vtx(123456, -654321, 4242, 1'b0));
		script.push_back(vtx(-8000, 8000, 1, 1'b1));
		script.push_back(reg_row(REG_CONTACT_MARGIN, {31'h0, 23'h7FFFFF}));
		script.push_back(vtx(0, 0, 0, 1'b1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				settle();
				write_register(script[i].idx, script[i].data);
			end else begin
				push_vertex(script[i].x, script[i].y, script[i].z, script[i].last,
					script[i].typed, script[i].box);
			end
		end

		// Random meshes, one register setting per phase
		for (int p = 0; p < PHASES; p++) begin
			settle();
			calm = (p == 5);
			case (p)
				0: begin
					mat[0] = MATRIX_COL0_RESET;
					mat[1] = MATRIX_COL1_RESET;
					mat[2] = MATRIX_COL2_RESET;
					px = '0;
					py = '0;
					pz = '0;
					mg = '0;
					gn = CFG_DATA_BITS'(INFLATE_GAIN_RESET);
				end
				1: begin
					for (int c = 0; c < 3; c++)
						mat[c] = {3{18'h1FFFF}};
					px = {30'h3FFFFFFF, COORD_MAX};
					py = {30'h3FFFFFFF, COORD_MAX};
					pz = {30'h3FFFFFFF, COORD_MAX};
					mg = '1;
					gn = '1;
				end
				2: begin
					for (int c = 0; c < 3; c++)
						mat[c] = {3{18'h20000}};
					px = {30'h0, COORD_MIN};
					py = {30'h0, COORD_MIN};
					pz = {30'h0, COORD_MIN};
					mg = '0;
					gn = '0;
				end
				default: begin
					for (int c = 0; c < 3; c++)
						for (int rw = 0; rw < 3; rw++) begin
							coefv = (p % 2) ? $urandom : $urandom_range(0, 32768) - 16384;
							mat[c][rw*COEF_FIELD_BITS +: COEF_FIELD_BITS] =
								coefv[COEF_FIELD_BITS-1:0];
						end
					px = CFG_DATA_BITS'({$urandom, $urandom});
					py = CFG_DATA_BITS'({$urandom, $urandom});
					pz = CFG_DATA_BITS'({$urandom, $urandom});
					mg = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'({$urandom, $urandom})
						: CFG_DATA_BITS'($urandom_range(0, 4096));
					gn = ($urandom_range(0, 1) == 0) ? CFG_DATA_BITS'({$urandom, $urandom})
						: CFG_DATA_BITS'($urandom_range(8192, 32768));
				end
			endcase
			write_register(REG_MATRIX_COL0, mat[0]);
			write_register(REG_MATRIX_COL1, mat[1]);
			write_register(REG_MATRIX_COL2, mat[2]);
			write_register(REG_POSE_X, px);
			write_register(REG_POSE_Y, py);
			write_register(REG_POSE_Z, pz);
			write_register(REG_CONTACT_MARGIN, mg);
			write_register(REG_INFLATE_GAIN, gn);

			// mostly short meshes, a few long ones
			sent = 0;
			while (sent < PHASE_LEN) begin
				r = $urandom_range(0, 99);
				mesh_len = (r < 70) ? $urandom_range(1, 4)
					: (r < 95) ? $urandom_range(5, 16) : $urandom_range(17, 60);
				for (int k = 0; k < mesh_len; k++)
					push_vertex(random_coord(), random_coord(), random_coord(),
						k == mesh_len - 1, 1'b0, '0);
				sent += mesh_len;
			end
		end

		calm = 1'b0;
		settle();
		if (errors == 0)
			$display("transformed_vertex_bounds regression: pass");
		else
			$display("transformed_vertex_bounds regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/tvb_pkg.sv
rtl/tvb_front.sv
rtl/tvb_queue.sv
rtl/tvb_back.sv
rtl/transformed_vertex_bounds.sv
dv/transformed_vertex_bounds_test.sv
